// ===== rtl/scc_pkg.sv =====
// Shared types, codes and defaults for the strongly connected components block.
package scc_pkg;

  localparam int MAX_VERTICES_DEFAULT = 16;
  localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
  } in_t;

  typedef struct packed {
    logic [3:0] vertex;
    logic       component_end;
    logic       done_res;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_SCAN,
    ST_CMP,
    ST_END,
    ST_RET,
    ST_RET_WAIT,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic row_rd;
    logic q_skip;
    logic enter;
    logic dfs_rd;
    logic cmp;
    logic ret_rd;
    logic ret_wr;
    logic pop_rd;
    logic pop_take;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic is_root;
    logic q_end;
    logic edge_hit;
    logic fin_q;
    logic vis_q;
    logic low_eq;
    logic pop_last;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/scc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scc_controller.sv =====
// Sequencer for row loads and the depth-first component search.
module scc_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  input  scc_pkg::status_t  status,
  output logic              in_stall,
  output scc_pkg::cmd_t     cmd
);

  scc_pkg::state_t state;
  scc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      scc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == scc_pkg::OP_RUN) begin
            cmd.start  = 1'b1;
            state_next = scc_pkg::ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      scc_pkg::ST_ROW: begin
        cmd.row_rd = 1'b1;
        state_next = scc_pkg::ST_SCAN;
      end
      scc_pkg::ST_SCAN: begin
        if (status.q_end) begin
          state_next = scc_pkg::ST_END;
        end else if (!status.edge_hit || status.fin_q) begin
          cmd.q_skip = 1'b1;
        end else if (!status.vis_q) begin
          cmd.enter  = 1'b1;
          state_next = scc_pkg::ST_ROW;
        end else begin
          cmd.dfs_rd = 1'b1;
          state_next = scc_pkg::ST_CMP;
        end
      end
      scc_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = scc_pkg::ST_SCAN;
      end
      scc_pkg::ST_END: begin
        if (!status.is_root && status.low_eq) begin
          state_next = scc_pkg::ST_POP_RD;
        end else begin
          state_next = scc_pkg::ST_RET;
        end
      end
      scc_pkg::ST_RET: begin
        if (status.is_root) begin
          state_next = scc_pkg::ST_FLUSH;
        end else begin
          cmd.ret_rd = 1'b1;
          state_next = scc_pkg::ST_RET_WAIT;
        end
      end
      scc_pkg::ST_RET_WAIT: begin
        cmd.ret_wr = 1'b1;
        state_next = scc_pkg::ST_ROW;
      end
      scc_pkg::ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = scc_pkg::ST_POP_WAIT;
      end
      scc_pkg::ST_POP_WAIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.pop_take = 1'b1;
          state_next   = status.pop_last ? scc_pkg::ST_RET : scc_pkg::ST_POP_RD;
        end
      end
      scc_pkg::ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = scc_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/scc_datapath.sv =====
// Graph storage, search stacks, frame registers and result buffering.
module scc_datapath #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [4:0]        cfg_data,
  input  scc_pkg::in_t      in_data,
  input  scc_pkg::cmd_t     cmd,
  input  logic              out_stall,
  output logic              out_valid,
  output scc_pkg::out_t     out_data,
  output scc_pkg::status_t  status
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int QW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = $clog2(MAX_VERTICES + 2);
  localparam int FW  = VIW + QW + 2 * CW;

  logic [4:0]              vertex_count;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] finished;
  logic                    pend_valid;

  logic [VIW-1:0] top_v;
  logic [QW-1:0]  top_q;
  logic [CW-1:0]  top_low;
  logic [CW-1:0]  top_dfs;
  logic [CW-1:0]  ret_low;
  logic [CW-1:0]  counter;
  logic [QW-1:0]  cs_cnt;
  logic [QW-1:0]  vs_cnt;
  logic [VIW-1:0] pend_vertex;
  logic           pend_end;

  logic [MAX_VERTICES-1:0] adj_rd;
  logic [CW-1:0]           dfs_rd;
  logic [FW-1:0]           call_rd;
  logic [VIW-1:0]          vs_rd;

  logic [QW+4:0]            vc_w;
  logic [QW-1:0]            n_use;
  logic [VIW+3:0]           ri_w;
  logic                     load_ok;
  logic [MAX_VERTICES+15:0] rb_w;
  logic [VIW-1:0]           q_idx;
  logic [QW-1:0]            q_inc;
  logic [QW-1:0]            cs_dec;
  logic [QW-1:0]            vs_dec;
  logic [FW-1:0]            frame;
  logic [VIW-1:0]           frame_v;
  logic [QW-1:0]            frame_next;
  logic [CW-1:0]            frame_low;
  logic [CW-1:0]            frame_dfs;
  logic [VIW+3:0]           pv_w;

  always_comb begin
    vc_w       = {{QW{1'b0}}, vertex_count};
    n_use      = (vc_w > (QW + 5)'(MAX_VERTICES)) ? QW'(MAX_VERTICES) : vc_w[QW-1:0];
    ri_w       = {{VIW{1'b0}}, in_data.row_index};
    load_ok    = ri_w < (VIW + 4)'(MAX_VERTICES);
    rb_w       = {{MAX_VERTICES{1'b0}}, in_data.row_bits};
    q_idx      = top_q[VIW-1:0];
    q_inc      = top_q + 1'b1;
    cs_dec     = cs_cnt - 1'b1;
    vs_dec     = vs_cnt - 1'b1;
    frame      = {top_v, q_inc, top_low, top_dfs};
    frame_v    = call_rd[FW-1:FW-VIW];
    frame_next = call_rd[QW+2*CW-1:2*CW];
    frame_low  = call_rd[2*CW-1:CW];
    frame_dfs  = call_rd[CW-1:0];
    pv_w       = {4'b0, pend_vertex};
  end

  always_comb begin
    status.is_root    = (cs_cnt == '0);
    status.q_end      = (top_q >= n_use);
    status.edge_hit   = status.is_root || adj_rd[q_idx];
    status.fin_q      = finished[q_idx];
    status.vis_q      = visited[q_idx];
    status.low_eq     = (top_low == top_dfs);
    status.pop_last   = (vs_rd == top_v);
    status.pend_valid = pend_valid;
    status.out_free   = !out_valid || !out_stall;
  end

  scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (ri_w[VIW-1:0]),
    .wdata (rb_w[MAX_VERTICES-1:0]),
    .re    (cmd.row_rd),
    .raddr (top_v),
    .rdata (adj_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_dfs_ram (
    .clk   (clk),
    .we    (cmd.enter),
    .waddr (q_idx),
    .wdata (counter),
    .re    (cmd.dfs_rd),
    .raddr (q_idx),
    .rdata (dfs_rd)
  );

  scc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_call_ram (
    .clk   (clk),
    .we    (cmd.enter),
    .waddr (cs_cnt[VIW-1:0]),
    .wdata (frame),
    .re    (cmd.ret_rd),
    .raddr (cs_dec[VIW-1:0]),
    .rdata (call_rd)
  );

  scc_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES)) u_vs_ram (
    .clk   (clk),
    .we    (cmd.enter),
    .waddr (vs_cnt[VIW-1:0]),
    .wdata (q_idx),
    .re    (cmd.pop_rd),
    .raddr (vs_dec[VIW-1:0]),
    .rdata (vs_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= scc_pkg::VERTEX_COUNT_RESET;
      visited      <= '0;
      finished     <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (cmd.start) begin
        visited  <= '0;
        finished <= '0;
      end
      if (cmd.enter) begin
        visited[q_idx] <= 1'b1;
      end
      if (cmd.pop_take) begin
        finished[vs_rd] <= 1'b1;
        pend_valid      <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.pop_take && pend_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      top_v   <= '0;
      top_q   <= '0;
      top_low <= '0;
      top_dfs <= '0;
      counter <= CW'(1);
      cs_cnt  <= '0;
      vs_cnt  <= '0;
    end
    if (cmd.enter) begin
      top_v   <= q_idx;
      top_q   <= '0;
      top_low <= counter;
      top_dfs <= counter;
      counter <= counter + 1'b1;
      cs_cnt  <= cs_cnt + 1'b1;
      vs_cnt  <= vs_cnt + 1'b1;
    end
    if (cmd.q_skip) begin
      top_q <= q_inc;
    end
    if (cmd.cmp) begin
      top_q <= q_inc;
      if (dfs_rd < top_low) begin
        top_low <= dfs_rd;
      end
    end
    if (cmd.ret_rd) begin
      cs_cnt  <= cs_dec;
      ret_low <= top_low;
    end
    if (cmd.ret_wr) begin
      top_v   <= frame_v;
      top_q   <= frame_next;
      top_dfs <= frame_dfs;
      top_low <= (ret_low < frame_low) ? ret_low : frame_low;
    end
    if (cmd.pop_rd) begin
      vs_cnt <= vs_dec;
    end
    if (cmd.pop_take) begin
      pend_vertex <= vs_rd;
      pend_end    <= status.pop_last;
      if (pend_valid) begin
        out_data.vertex        <= pv_w[3:0];
        out_data.component_end <= pend_end;
        out_data.done_res      <= 1'b0;
      end
    end
    if (cmd.flush) begin
      out_data.vertex        <= pv_w[3:0];
      out_data.component_end <= pend_end;
      out_data.done_res      <= 1'b1;
    end
  end

endmodule

// ===== rtl/strongly_connected_components.sv =====
// Top level of the strongly connected components block.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     scc_pkg::in_t  (op, row_index, row_bits)
//   out      output     out_valid / out_stall   scc_pkg::out_t (vertex, component_end, done_res)
//   cfg      input      cfg_write               cfg_data (vertex_count)
//
// A row load is taken in ST_IDLE; in_stall stays low and the next transaction follows at once.
// A run tests one adjacency bit per cycle in ST_SCAN; each vertex entered, returned from and
// popped passes through further states (ST_ROW, ST_RET, ST_RET_WAIT, ST_POP_RD, ST_POP_WAIT),
// as the RAM reads are registered, and an edge into an open vertex adds an ST_CMP step.
// Each result sits one slot behind in a holding register, so out_stall held high stops the
// search once that slot and the output register are both full.
// Reset clears the controller, the output and the marks, and sets vertex_count to 16.
module strongly_connected_components #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  scc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output scc_pkg::out_t out_data,
  input  logic          cfg_write,
  input  logic [4:0]    cfg_data
);

  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t status;

  scc_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  scc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

// ===== rtl/scc_checker.sv =====
// Port-level assertions for the strongly connected components block, with its bind.
module scc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input scc_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input scc_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed or dropped");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.op == scc_pkg::OP_LOAD) |=> !in_stall)
    else $error("load transaction did not complete in one cycle");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.op == scc_pkg::OP_RUN) |=> in_stall)
    else $error("run transaction did not hold off the input");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.component_end)
    else $error("last result of a run does not close a component");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the strongly connected components block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VERTICES = scc_pkg::MAX_VERTICES_DEFAULT;
  localparam int ROOT = VERTICES;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  scc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scc_pkg::out_t out_data;
  logic cfg_write = 1'b0;
  logic [4:0] cfg_data = '0;

  logic [15:0] adjacency_rows[VERTICES];
  logic [4:0] vertex_count_reg = scc_pkg::VERTEX_COUNT_RESET;
  scc_pkg::out_t expected_vertices[$];
  scc_pkg::out_t want;
  int mismatch_count = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  strongly_connected_components DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("strongly_connected_components: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input scc_pkg::out_t got,
                                 input scc_pkg::out_t exp);
    $display("%0t %s: got vertex %0d end %0b done %0b, want vertex %0d end %0b done %0b",
             $realtime, what, got.vertex, got.component_end, got.done_res,
             exp.vertex, exp.component_end, exp.done_res);
    mismatch_count++;
  endtask

  // Tarjan walk from a super-root that reaches every vertex in use.
  function automatic void predict_components();
    int n, depth, vdepth, counter, p, q, v, k, parent;
    bit hit, descended;
    int dfs[VERTICES + 1];
    int low[VERTICES + 1];
    int call_v[VERTICES + 1];
    int call_q[VERTICES + 1];
    int vstack[VERTICES + 1];
    bit seen[VERTICES + 1];
    bit closed[VERTICES + 1];
    scc_pkg::out_t res[VERTICES];
    n = (vertex_count_reg > VERTICES) ? VERTICES : int'(vertex_count_reg);
    if (n == 0) return;
    for (int i = 0; i <= VERTICES; i++) begin
      seen[i] = 1'b0;
      closed[i] = 1'b0;
    end
    k = 0;
    vdepth = 0;
    seen[ROOT] = 1'b1;
    dfs[ROOT] = 0;
    low[ROOT] = 0;
    counter = 1;
    call_v[0] = ROOT;
    call_q[0] = 0;
    depth = 1;
    while (depth > 0) begin
      p = call_v[depth - 1];
      q = call_q[depth - 1];
      descended = 1'b0;
      while (q < n) begin
        hit = (p == ROOT) || adjacency_rows[p][q];
        if (hit && !closed[q]) begin
          if (!seen[q]) begin
            call_q[depth - 1] = q + 1;
            vstack[vdepth] = q;
            vdepth++;
            seen[q] = 1'b1;
            dfs[q] = counter;
            low[q] = counter;
            counter++;
            call_v[depth] = q;
            call_q[depth] = 0;
            depth++;
            descended = 1'b1;
            break;
          end
          if (dfs[q] < low[p]) low[p] = dfs[q];
        end
        q++;
      end
      if (!descended) begin
        depth--;
        if (p != ROOT && low[p] == dfs[p]) begin
          do begin
            vdepth--;
            v = vstack[vdepth];
            closed[v] = 1'b1;
            res[k].vertex = v[3:0];
            res[k].component_end = (v == p);
            res[k].done_res = 1'b0;
            k++;
          end while (v != p && vdepth > 0);
        end
        if (depth > 0) begin
          parent = call_v[depth - 1];
          if (low[p] < low[parent]) low[parent] = low[p];
        end
      end
    end
    if (k > 0) res[k - 1].done_res = 1'b1;
    for (int i = 0; i < k; i++) expected_vertices.push_back(res[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected transaction", out_data, '0);
      end else begin
        want = expected_vertices.pop_front();
        if (out_data.vertex !== want.vertex || out_data.component_end !== want.component_end ||
            out_data.done_res !== want.done_res) begin
          report_mismatch("wrong result", out_data, want);
        end
      end
    end
    out_stall <= stall_on && ($urandom_range(99) < 15);
  end

  task automatic send_item(input scc_pkg::in_t item);
    if (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.op == scc_pkg::OP_LOAD) adjacency_rows[item.row_index] = item.row_bits;
    else predict_components();
  endtask

  task automatic load_row(input int row, input logic [15:0] bits);
    scc_pkg::in_t item;
    item.op = scc_pkg::OP_LOAD;
    item.row_index = row[3:0];
    item.row_bits = bits;
    send_item(item);
  endtask

  task automatic run_search();
    scc_pkg::in_t item;
    item.op = scc_pkg::OP_RUN;
    item.row_index = 4'($urandom);
    item.row_bits = 16'($urandom);
    send_item(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_data <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    vertex_count_reg = value;
  endtask

  function automatic logic [15:0] random_row();
    case ($urandom_range(3))
      0: return 16'd1 << $urandom_range(15);
      1: return (16'd1 << $urandom_range(15)) | (16'd1 << $urandom_range(15));
      2: return 16'($urandom & $urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_full_load();
    load_row(0, 16'hFFFF);
    for (int i = 1; i < VERTICES - 1; i++) begin
      load_row(i, (16'd1 << ((i + 1) % VERTICES)) | random_row());
    end
    load_row(VERTICES - 1, 16'h0000);
    run_search();
  endtask

  task automatic test_count_extremes();
    logic [4:0] counts[4];
    counts = '{5'd1, 5'd0, 5'd31, 5'd17};
    foreach (counts[i]) begin
      wait_idle();
      write_count(counts[i]);
      run_search();
    end
  endtask

  task automatic test_random_graphs();
    int sent, loads;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      idle_on = (phase != 2);
      stall_on = (phase != 2);
      if (phase == 0) write_count(5'd16);
      else if (phase == 1) write_count(5'd1);
      else write_count(5'($urandom_range(1, VERTICES)));
      sent = 0;
      while (sent < 19) begin
        if ($urandom_range(99) < 85) begin
          loads = $urandom_range(1, 4);
          repeat (loads) load_row($urandom_range(VERTICES - 1), random_row());
          run_search();
          sent += loads + 1;
        end else if ($urandom_range(1)) begin
          run_search();
          sent++;
        end else begin
          load_row($urandom_range(VERTICES - 1), random_row());
          sent++;
        end
      end
    end
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_full_load();
    test_count_extremes();
    test_random_graphs();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("strongly_connected_components: match");
    end else begin
      $display("strongly_connected_components: mismatch");
    end
    $finish;
  end

endmodule
